// File: hw/rtl/tagged_message_buffer_macros.svh
// ----------------------------------------------------------------------------
// tagged_message_buffer assertion macros
// Shared concurrent assertion shorthands; expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef TAGGED_MESSAGE_BUFFER_MACROS_SVH
`define TAGGED_MESSAGE_BUFFER_MACROS_SVH

// Same-cycle implication.
`define TMB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TMB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/tmb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmb_pkg
// Types and codes shared by the tagged message buffer modules.
// ----------------------------------------------------------------------------
package tmb_pkg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_NOMATCH = 2'd2;

    localparam logic [2:0] ADDR_WARN_THRESHOLD = 3'd0;
    localparam logic [6:0] WARN_THRESHOLD_RESET = 7'd48;

    typedef struct packed {
        logic [7:0] id;
        logic [7:0] data;
    } tmb_packet_t;

    typedef struct packed {
        logic load_en;
        logic capture;
        logic shift_en;
    } tmb_cell_ctrl_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] read_dev_id;
        logic [7:0] read_data;
        logic       near_full;
        logic [6:0] occupancy;
    } tmb_result_t;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } tmb_state_t;

endpackage

// File: hw/rtl/tmb_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmb_in_if
// Command channel: valid/ready with one command transaction as payload.
// ----------------------------------------------------------------------------
interface tmb_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] dev_id;
    logic [7:0] data;

    modport source (output valid, output cmd, output dev_id, output data, input ready);
    modport sink   (input valid, input cmd, input dev_id, input data, output ready);
endinterface

// File: hw/rtl/tmb_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmb_out_if
// Result channel: valid/ready with one result transaction as payload.
// ----------------------------------------------------------------------------
interface tmb_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] read_dev_id;
    logic [7:0] read_data;
    logic       near_full;
    logic [6:0] occupancy;

    modport source (output valid, output status, output read_dev_id, output read_data,
                    output near_full, output occupancy, input ready);
    modport sink   (input valid, input status, input read_dev_id, input read_data,
                    input near_full, input occupancy, output ready);
endinterface

// File: hw/rtl/tmb_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmb_cell
// One slot of the packet chain: loads and holds a packet, flags an id match, and takes
// its upper neighbor's packet when the chain compacts.
// ----------------------------------------------------------------------------
module tmb_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                    clk,
    input  tmb_pkg::tmb_cell_ctrl_t ctrl,
    input  logic [CW-1:0]           count,
    input  logic [7:0]              key,
    input  tmb_pkg::tmb_packet_t    wr_pkt,
    input  tmb_pkg::tmb_packet_t    upper_pkt,
    input  logic                    above,
    output tmb_pkg::tmb_packet_t    pkt,
    output logic                    hit
);

    tmb_pkg::tmb_packet_t pkt_reg;
    tmb_pkg::tmb_packet_t pkt_next;
    logic                 match_reg;
    logic                 match_next;

    always_comb
    begin
        pkt_next = pkt_reg;
        if (ctrl.load_en && (count == CW'(IDX)))
        begin
            pkt_next = wr_pkt;
        end
        else if (ctrl.shift_en && !above)
        begin
            // at or above the removed slot: move down one
            pkt_next = upper_pkt;
        end
    end

    assign match_next = ctrl.capture ? (pkt_reg.id == key) : match_reg;

    always_ff @(posedge clk)
    begin
        pkt_reg   <= pkt_next;
        match_reg <= match_next;
    end

    assign pkt = pkt_reg;
    assign hit = match_reg && (CW'(IDX) < count);

endmodule

// File: hw/rtl/tmb_ctrl.sv
`timescale 1ns / 1ps
`include "tagged_message_buffer_macros.svh"
// ----------------------------------------------------------------------------
// tmb_ctrl
// Command sequencer: fill count, chain control and the result register.
// ----------------------------------------------------------------------------
module tmb_ctrl #(
    parameter int DEPTH = 64,
    parameter int CW    = 7
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_fire,
    input  logic                    in_cmd,
    input  logic                    out_ready,
    input  logic                    found,
    input  tmb_pkg::tmb_packet_t    sel_pkt,
    input  logic [6:0]              warn_threshold,
    output logic                    in_ready,
    output tmb_pkg::tmb_cell_ctrl_t cell_ctrl,
    output logic [CW-1:0]           count,
    output logic                    out_valid,
    output tmb_pkg::tmb_result_t    result
);

    tmb_pkg::tmb_state_t  state_reg;
    tmb_pkg::tmb_state_t  state_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 res_valid_reg;
    logic                 res_valid_next;
    tmb_pkg::tmb_result_t res_reg;
    tmb_pkg::tmb_result_t res_next;
    logic                 res_load;
    logic [CW:0]          count_plus;
    logic [CW-1:0]        count_less;
    logic [CW+6:0]        occ_ext;
    logic                 warn;
    logic                 full;
    logic                 searching;

    assign count_plus = {1'b0, count_reg} + (CW+1)'(1);
    assign count_less = count_reg - CW'(1);
    assign warn       = {6'b0, count_plus} > {{CW{1'b0}}, warn_threshold};
    assign full       = (count_reg == CW'(DEPTH));
    assign occ_ext    = {7'b0, count_next};
    assign searching  = (state_reg == tmb_pkg::ST_SEARCH);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tmb_pkg::ST_IDLE:
            begin
                if (in_fire && (in_cmd == tmb_pkg::CMD_READ))
                begin
                    state_next = tmb_pkg::ST_SEARCH;
                end
            end
            tmb_pkg::ST_SEARCH:
            begin
                state_next = tmb_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tmb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cell_ctrl  = '0;
        count_next = count_reg;
        res_load   = 1'b0;
        res_next   = '0;
        unique case (state_reg)
            tmb_pkg::ST_IDLE:
            begin
                in_ready = !res_valid_reg || out_ready;
                if (in_fire)
                begin
                    if (in_cmd == tmb_pkg::CMD_WRITE)
                    begin
                        res_load = 1'b1;
                        if (full)
                        begin
                            res_next.status = tmb_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            cell_ctrl.load_en  = 1'b1;
                            count_next         = count_plus[CW-1:0];
                            res_next.status    = tmb_pkg::STATUS_DONE;
                            res_next.near_full = warn;
                        end
                    end
                    else
                    begin
                        // latch per-cell match flags against the search id
                        cell_ctrl.capture = 1'b1;
                    end
                end
            end
            tmb_pkg::ST_SEARCH:
            begin
                res_load = 1'b1;
                if (found)
                begin
                    cell_ctrl.shift_en   = 1'b1;
                    count_next           = count_less;
                    res_next.status      = tmb_pkg::STATUS_DONE;
                    res_next.read_dev_id = sel_pkt.id;
                    res_next.read_data   = sel_pkt.data;
                end
                else
                begin
                    res_next.status = tmb_pkg::STATUS_NOMATCH;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        res_next.occupancy = occ_ext[6:0];
    end

    assign res_valid_next = res_load ? 1'b1 : (out_ready ? 1'b0 : res_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tmb_pkg::ST_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    assign count     = count_reg;
    assign out_valid = res_valid_reg;
    assign result    = res_reg;

    `TMB_ASSERT_IMP(a_count_max, 1'b1, count_reg <= CW'(DEPTH), "fill count above depth")
    `TMB_ASSERT_NXT(a_search_one_cycle, searching, !searching, "search state held")
    `TMB_ASSERT_NXT(a_take_dec, searching && found, count_reg == $past(count_less), "not removed")
    `TMB_ASSERT_IMP(a_search_out_free, searching, !res_valid_reg, "result busy in search")

endmodule

// File: hw/rtl/tagged_message_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_message_buffer
// Mailbox of DEPTH id/data packets kept in a compacting chain of cells;
// writes append at the top, reads take the newest packet with a matching id.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  req     | in        | valid/ready       | cmd, dev_id, data
//  rsp     | out       | valid/ready       | status, read_dev_id, read_data,
//          |           |                   | near_full, occupancy
//  apb     | in/out    | psel/penable      | warn_threshold at byte address 0
//
//  A write: the cell at the fill count loads on the accept edge.
//  A read: match flags latch in every cell on the accept edge, then the newest
//  match is picked and the cells above it shift down in one step.
//  The next command is taken in idle once the result register is empty or being read.
//  Reset clears the fill count and sets warn_threshold to 48; no clearing pass.
// ----------------------------------------------------------------------------
module tagged_message_buffer #(
    parameter int DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    tmb_in_if.sink      req,
    tmb_out_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [6:0]              thr_reg;
    logic [6:0]              thr_next;
    logic                    cfg_wr;
    logic                    in_fire;
    logic                    in_ready;
    logic                    found;
    logic [CW-1:0]           count;
    logic                    out_valid;
    tmb_pkg::tmb_cell_ctrl_t cell_ctrl;
    tmb_pkg::tmb_result_t    result;
    tmb_pkg::tmb_packet_t    wr_pkt;
    tmb_pkg::tmb_packet_t    sel_pkt;
    tmb_pkg::tmb_packet_t    pkt   [DEPTH];
    tmb_pkg::tmb_packet_t    upper [DEPTH];
    logic [DEPTH-1:0]        hit_vec;
    logic [DEPTH-1:0]        above;

    // configuration port
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr == tmb_pkg::ADDR_WARN_THRESHOLD);
    assign thr_next = cfg_wr ? pwdata[6:0] : thr_reg;
    assign prdata   = (paddr == tmb_pkg::ADDR_WARN_THRESHOLD) ? {25'b0, thr_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= tmb_pkg::WARN_THRESHOLD_RESET;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    assign in_fire     = req.valid && in_ready;
    assign req.ready   = in_ready;
    assign wr_pkt.id   = req.dev_id;
    assign wr_pkt.data = req.data;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        if (g == DEPTH - 1)
        begin : g_top
            assign above[g] = 1'b0;
            assign upper[g] = pkt[g];
        end
        else
        begin : g_mid
            // any live match newer than this slot
            assign above[g] = |hit_vec[DEPTH-1:g+1];
            assign upper[g] = pkt[g+1];
        end

        tmb_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl),
            .count     (count),
            .key       (req.dev_id),
            .wr_pkt    (wr_pkt),
            .upper_pkt (upper[g]),
            .above     (above[g]),
            .pkt       (pkt[g]),
            .hit       (hit_vec[g])
        );
    end

    assign found = |hit_vec;

    // one-hot select of the newest match
    always_comb
    begin
        sel_pkt = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (hit_vec[i] && !above[i])
            begin
                sel_pkt = sel_pkt | pkt[i];
            end
        end
    end

    tmb_ctrl #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_fire        (in_fire),
        .in_cmd         (req.cmd),
        .out_ready      (rsp.ready),
        .found          (found),
        .sel_pkt        (sel_pkt),
        .warn_threshold (thr_reg),
        .in_ready       (in_ready),
        .cell_ctrl      (cell_ctrl),
        .count          (count),
        .out_valid      (out_valid),
        .result         (result)
    );

    assign rsp.valid       = out_valid;
    assign rsp.status      = result.status;
    assign rsp.read_dev_id = result.read_dev_id;
    assign rsp.read_data   = result.read_data;
    assign rsp.near_full   = result.near_full;
    assign rsp.occupancy   = result.occupancy;

endmodule
